// ===== rtl/adp_pkg.sv =====
package adp_pkg;

  localparam int unsigned IMAGE_WIDTH      = 512;
  localparam int unsigned IMAGE_HEIGHT     = 512;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;

  localparam int unsigned POINT_W    = 16;
  localparam int unsigned FIELD_W    = 9;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam int unsigned ROW_W      = $clog2(IMAGE_HEIGHT);
  localparam int unsigned COL_W      = $clog2(IMAGE_WIDTH);
  localparam int unsigned ROW_EXT_W  = $clog2(IMAGE_HEIGHT + 1);
  localparam int unsigned COL_EXT_W  = $clog2(IMAGE_WIDTH + 1);
  localparam int unsigned ROW_PROD_W = POINT_W + ROW_EXT_W;
  localparam int unsigned COL_PROD_W = POINT_W + COL_EXT_W;
  localparam int unsigned IMG_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(IMG_DEPTH);

  localparam int unsigned PH_FULL = 4 * SINE_TABLE_DEPTH;
  localparam int unsigned PH_W    = $clog2(PH_FULL + 1);
  localparam int unsigned PHX_W   = PH_W + 1;
  localparam int unsigned SCL_W   = 32 + PH_W;
  localparam int unsigned QT_AW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned QT_DW   = 14;

  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
  localparam logic [63:0] PI_HALF_Q30     = 64'd1686629713;
  localparam logic [63:0] Q13_ONE         = 64'd8192;

  localparam logic [COUNT_W-1:0] HIT_MAX = 8'd200;

  localparam logic [POINT_W-1:0] COEF_A_RST = 16'd13443;
  localparam logic [POINT_W-1:0] COEF_B_RST = 16'd15581;
  localparam logic [POINT_W-1:0] COEF_C_RST = 16'd2589;
  localparam logic [POINT_W-1:0] COEF_D_RST = 16'd12493;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_D = 8'd3;

  typedef enum logic [1:0] {
    ACT_ITERATE = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_READ    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_COLLECT,
    ST_PIXEL,
    ST_UPDATE,
    ST_WAIT_MEM,
    ST_EMIT
  } adp_state_e;

  typedef struct packed {
    logic               valid;
    logic               cosine;
    logic [POINT_W-1:0] coef;
    logic [POINT_W-1:0] point;
  } phs_req_t;

  typedef struct packed {
    logic               valid;
    logic [POINT_W-1:0] value;
  } phs_rsp_t;

  typedef struct packed {
    logic              valid;
    logic              incr;
    logic [ADDR_W-1:0] addr;
  } dens_req_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } dens_rsp_t;

  typedef logic [SINE_TABLE_DEPTH:0][QT_DW-1:0] qtab_t;

  // Quarter-wave sine in Q13 from a Q30 Taylor series through the t^13 term
  function automatic qtab_t build_qtab();
    qtab_t              tab;
    logic        [63:0] t;
    logic        [63:0] mag;
    logic signed [63:0] sum;
    logic        [63:0] e;
    tab = '0;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      t   = (64'(k) * PI_HALF_Q30) / SINE_TABLE_DEPTH;
      mag = t;
      sum = $signed(t);
      mag = (((mag * t) >> 30) * t) >> 30;
      mag = mag / 64'd6;
      sum = sum - $signed(mag);
      mag = (((mag * t) >> 30) * t) >> 30;
      mag = mag / 64'd20;
      sum = sum + $signed(mag);
      mag = (((mag * t) >> 30) * t) >> 30;
      mag = mag / 64'd42;
      sum = sum - $signed(mag);
      mag = (((mag * t) >> 30) * t) >> 30;
      mag = mag / 64'd72;
      sum = sum + $signed(mag);
      mag = (((mag * t) >> 30) * t) >> 30;
      mag = mag / 64'd110;
      sum = sum - $signed(mag);
      mag = (((mag * t) >> 30) * t) >> 30;
      mag = mag / 64'd156;
      sum = sum + $signed(mag);
      if (sum < 0) begin
        sum = '0;
      end
      e = ($unsigned(sum) + 64'h1_0000) >> 17;
      if (e > Q13_ONE) begin
        e = Q13_ONE;
      end
      tab[k] = e[QT_DW-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

// ===== rtl/adp_phase.sv =====
module adp_phase (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  adp_pkg::phs_req_t req_i,
  output adp_pkg::phs_rsp_t rsp_o
);

  logic [4:0] vld_q;

  logic signed [31:0] prod_s1;
  logic signed [31:0] prod1_q;
  logic               cos1_q;

  logic signed [64:0] wide_s2;
  logic        [31:0] frac2_q;
  logic               cos2_q;

  logic [adp_pkg::SCL_W-1:0] scaled_s3;
  logic [adp_pkg::PH_W-1:0]  phase3_q;
  logic                      cos3_q;

  logic [adp_pkg::PHX_W-1:0] p0;
  logic [adp_pkg::PHX_W-1:0] p1;
  logic [adp_pkg::PHX_W-1:0] r_full;
  logic [1:0]                quad;
  logic [adp_pkg::QT_AW-1:0] r_low;
  logic [adp_pkg::QT_AW-1:0] rom_addr;
  logic [adp_pkg::QT_DW-1:0] rom4_q;
  logic                      neg4_q;

  logic [adp_pkg::POINT_W-1:0] ext_s5;
  logic [adp_pkg::POINT_W-1:0] val5_q;

  assign prod_s1 = $signed({{16{req_i.coef[15]}}, req_i.coef}) *
                   $signed({{16{req_i.point[15]}}, req_i.point});

  assign wide_s2 = prod1_q * $signed({1'b0, adp_pkg::TWO_OVER_PI_Q32});

  assign scaled_s3 = adp_pkg::SCL_W'(frac2_q) * adp_pkg::SCL_W'(adp_pkg::PH_FULL) +
                     adp_pkg::SCL_W'(64'h8000_0000);

  always_comb begin
    p0 = (phase3_q == adp_pkg::PH_W'(adp_pkg::PH_FULL)) ? '0 : {1'b0, phase3_q};
    p1 = p0;
    if (cos3_q) begin
      p1 = p0 + adp_pkg::PHX_W'(adp_pkg::SINE_TABLE_DEPTH);
    end
    if (p1 >= adp_pkg::PHX_W'(adp_pkg::PH_FULL)) begin
      p1 = p1 - adp_pkg::PHX_W'(adp_pkg::PH_FULL);
    end
    if (p1 < adp_pkg::PHX_W'(adp_pkg::SINE_TABLE_DEPTH)) begin
      quad   = 2'd0;
      r_full = p1;
    end else if (p1 < adp_pkg::PHX_W'(2 * adp_pkg::SINE_TABLE_DEPTH)) begin
      quad   = 2'd1;
      r_full = p1 - adp_pkg::PHX_W'(adp_pkg::SINE_TABLE_DEPTH);
    end else if (p1 < adp_pkg::PHX_W'(3 * adp_pkg::SINE_TABLE_DEPTH)) begin
      quad   = 2'd2;
      r_full = p1 - adp_pkg::PHX_W'(2 * adp_pkg::SINE_TABLE_DEPTH);
    end else begin
      quad   = 2'd3;
      r_full = p1 - adp_pkg::PHX_W'(3 * adp_pkg::SINE_TABLE_DEPTH);
    end
    r_low    = r_full[adp_pkg::QT_AW-1:0];
    rom_addr = quad[0] ? adp_pkg::QT_AW'(adp_pkg::SINE_TABLE_DEPTH) - r_low : r_low;
  end

  assign ext_s5 = {{(adp_pkg::POINT_W - adp_pkg::QT_DW){1'b0}}, rom4_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q  <= prod_s1;
    cos1_q   <= req_i.cosine;
    frac2_q  <= wide_s2[59:28];
    cos2_q   <= cos1_q;
    phase3_q <= scaled_s3[adp_pkg::SCL_W-1:32];
    cos3_q   <= cos2_q;
    rom4_q   <= adp_pkg::QTAB[rom_addr];
    neg4_q   <= quad[1];
    val5_q   <= neg4_q ? -ext_s5 : ext_s5;
  end

  assign rsp_o.valid = vld_q[4];
  assign rsp_o.value = val5_q;

endmodule

// ===== rtl/adp_density.sv =====
module adp_density (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  adp_pkg::dens_req_t req_i,
  output adp_pkg::dens_rsp_t rsp_o,
  output logic               busy_o
);

  logic [adp_pkg::COUNT_W-1:0] mem_q [0:adp_pkg::IMG_DEPTH-1];

  logic                        busy_q;
  logic [adp_pkg::ADDR_W-1:0]  clr_cnt_q;
  logic                        pend_q;
  logic                        incr_q;
  logic [adp_pkg::ADDR_W-1:0]  addr_q;
  logic [adp_pkg::COUNT_W-1:0] rd_q;
  logic [adp_pkg::COUNT_W-1:0] bumped;

  assign bumped = (rd_q < adp_pkg::HIT_MAX) ? rd_q + 8'd1 : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      pend_q <= req_i.valid;
      if (clear_i) begin
        busy_q    <= 1'b1;
        clr_cnt_q <= '0;
      end else if (busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == adp_pkg::ADDR_W'(adp_pkg::IMG_DEPTH - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    incr_q <= req_i.incr;
    addr_q <= req_i.addr;
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (pend_q && incr_q) begin
      mem_q[addr_q] <= bumped;
    end
    rd_q <= mem_q[req_i.addr];
  end

  assign rsp_o.valid = pend_q;
  assign rsp_o.count = incr_q ? bumped : rd_q;
  assign busy_o      = busy_q;

  a_no_req_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> !busy_q)
    else $error("image access during clearing pass");

  a_single_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !req_i.valid)
    else $error("overlapping read-modify-write");

endmodule

// ===== rtl/attractor_density_plotter_unit.sv =====
// Channel  | Dir | Beat
// s_axis   | in  | tuser: action; tdata: seed_x, seed_y, read_row, read_col
// m_axis   | out | tdata: point_x, point_y, pixel_row, pixel_col, hit_count
// cfg      | in  | cfg_index_i selects coef_a..coef_d, cfg_data_i is the value
//
// Iterate: four lookups through the five-stage sine/cosine pipeline, pixel
// mapping, one read-modify-write of the image RAM. Read: one image RAM read
// when row and col are in range. Restart and unused actions go straight to emit.
// Reset and restart run a clearing pass over all 262144 pixels (one pixel a cycle);
// s_axis_tready stays low during it, cfg writes are still taken.
// The result sits in an output register; the next beat is taken while it waits.
module attractor_density_plotter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] seed_x, [31:16] seed_y, [40:32] read_row, [49:41] read_col
  input  logic [adp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] point_x, [31:16] point_y, [40:32] pixel_row, [49:41] pixel_col,
  // [57:50] hit_count
  output logic [adp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [adp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [adp_pkg::POINT_W-1:0]      cfg_data_i
);

  adp_pkg::adp_state_e state_q, state_d;

  logic [adp_pkg::POINT_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic [adp_pkg::POINT_W-1:0] cur_x_q, cur_y_q;
  logic signed [adp_pkg::POINT_W-1:0] nx_q, ny_q;
  logic [1:0] issue_cnt_q, res_cnt_q;
  logic       incr_q;
  logic [adp_pkg::ROW_W-1:0]   addr_row_q;
  logic [adp_pkg::COL_W-1:0]   addr_col_q;
  logic [adp_pkg::FIELD_W-1:0] res_row_q, res_col_q;
  logic [adp_pkg::COUNT_W-1:0] count_q;
  logic                        m_valid_q;
  logic [adp_pkg::OUT_TDATA_W-1:0] m_data_q;

  adp_pkg::phs_req_t  phs_req;
  adp_pkg::phs_rsp_t  phs_rsp;
  adp_pkg::dens_req_t dens_req;
  adp_pkg::dens_rsp_t dens_rsp;
  logic               dens_busy;
  logic               clear_start;
  logic               emit;

  adp_pkg::action_e            in_action;
  logic [adp_pkg::POINT_W-1:0] in_seed_x, in_seed_y;
  logic [adp_pkg::FIELD_W-1:0] in_row, in_col;
  logic                        accept;
  logic                        in_range;
  logic                        out_free;
  logic signed [adp_pkg::POINT_W-1:0] phs_val;

  logic [adp_pkg::ROW_W+adp_pkg::FIELD_W-1:0] in_row_ext;
  logic [adp_pkg::COL_W+adp_pkg::FIELD_W-1:0] in_col_ext;

  logic [adp_pkg::POINT_W-1:0]    off_x, off_y;
  logic [adp_pkg::ROW_PROD_W-1:0] row_prod;
  logic [adp_pkg::COL_PROD_W-1:0] col_prod;
  logic [adp_pkg::ROW_EXT_W-1:0]  row_idx;
  logic [adp_pkg::COL_EXT_W-1:0]  col_idx;
  logic [adp_pkg::ROW_EXT_W+adp_pkg::FIELD_W-1:0] row_out_ext;
  logic [adp_pkg::COL_EXT_W+adp_pkg::FIELD_W-1:0] col_out_ext;

  assign in_action = adp_pkg::action_e'(s_axis_tuser);
  assign in_seed_x = s_axis_tdata[15:0];
  assign in_seed_y = s_axis_tdata[31:16];
  assign in_row    = s_axis_tdata[40:32];
  assign in_col    = s_axis_tdata[49:41];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_range  = (32'(in_row) < adp_pkg::IMAGE_HEIGHT) &&
                     (32'(in_col) < adp_pkg::IMAGE_WIDTH);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign phs_val   = $signed(phs_rsp.value);

  assign in_row_ext = {{adp_pkg::ROW_W{1'b0}}, in_row};
  assign in_col_ext = {{adp_pkg::COL_W{1'b0}}, in_col};

  // Map a point to a pixel: (v + 0.5 * 2^16) * size >> 16, clamped
  always_comb begin
    off_x    = cur_x_q ^ 16'h8000;
    off_y    = cur_y_q ^ 16'h8000;
    row_prod = adp_pkg::ROW_PROD_W'(off_y) * adp_pkg::ROW_PROD_W'(adp_pkg::IMAGE_HEIGHT);
    col_prod = adp_pkg::COL_PROD_W'(off_x) * adp_pkg::COL_PROD_W'(adp_pkg::IMAGE_WIDTH);
    row_idx  = row_prod[adp_pkg::ROW_PROD_W-1:adp_pkg::POINT_W];
    col_idx  = col_prod[adp_pkg::COL_PROD_W-1:adp_pkg::POINT_W];
    if (row_idx >= adp_pkg::ROW_EXT_W'(adp_pkg::IMAGE_HEIGHT)) begin
      row_idx = adp_pkg::ROW_EXT_W'(adp_pkg::IMAGE_HEIGHT - 1);
    end
    if (col_idx >= adp_pkg::COL_EXT_W'(adp_pkg::IMAGE_WIDTH)) begin
      col_idx = adp_pkg::COL_EXT_W'(adp_pkg::IMAGE_WIDTH - 1);
    end
    row_out_ext = {{adp_pkg::FIELD_W{1'b0}}, row_idx};
    col_out_ext = {{adp_pkg::FIELD_W{1'b0}}, col_idx};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      adp_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_action)
            adp_pkg::ACT_ITERATE: state_d = adp_pkg::ST_ISSUE;
            adp_pkg::ACT_READ:    state_d = in_range ? adp_pkg::ST_UPDATE : adp_pkg::ST_EMIT;
            default:              state_d = adp_pkg::ST_EMIT;
          endcase
        end
      end
      adp_pkg::ST_ISSUE: begin
        if (issue_cnt_q == 2'd3) begin
          state_d = adp_pkg::ST_COLLECT;
        end
      end
      adp_pkg::ST_COLLECT: begin
        if (phs_rsp.valid && res_cnt_q == 2'd3) begin
          state_d = adp_pkg::ST_PIXEL;
        end
      end
      adp_pkg::ST_PIXEL:  state_d = adp_pkg::ST_UPDATE;
      adp_pkg::ST_UPDATE: state_d = adp_pkg::ST_WAIT_MEM;
      adp_pkg::ST_WAIT_MEM: begin
        if (dens_rsp.valid) begin
          state_d = adp_pkg::ST_EMIT;
        end
      end
      adp_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = adp_pkg::ST_IDLE;
        end
      end
      default: state_d = adp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready  = (state_q == adp_pkg::ST_IDLE) && !dens_busy;
    clear_start    = accept && (in_action == adp_pkg::ACT_RESTART);
    emit           = (state_q == adp_pkg::ST_EMIT) && out_free;
    phs_req.valid  = (state_q == adp_pkg::ST_ISSUE);
    phs_req.cosine = issue_cnt_q[0];
    case (issue_cnt_q)
      2'd0: begin
        phs_req.coef  = coef_a_q;
        phs_req.point = cur_y_q;
      end
      2'd1: begin
        phs_req.coef  = coef_b_q;
        phs_req.point = cur_x_q;
      end
      2'd2: begin
        phs_req.coef  = coef_c_q;
        phs_req.point = cur_x_q;
      end
      default: begin
        phs_req.coef  = coef_d_q;
        phs_req.point = cur_y_q;
      end
    endcase
    dens_req.valid = (state_q == adp_pkg::ST_UPDATE);
    dens_req.incr  = incr_q;
    dens_req.addr  = adp_pkg::ADDR_W'(addr_row_q) * adp_pkg::ADDR_W'(adp_pkg::IMAGE_WIDTH) +
                     adp_pkg::ADDR_W'(addr_col_q);
  end

  adp_phase u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (phs_req),
    .rsp_o  (phs_rsp)
  );

  adp_density u_density (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear_start),
    .req_i   (dens_req),
    .rsp_o   (dens_rsp),
    .busy_o  (dens_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adp_pkg::ST_IDLE;
      coef_a_q    <= adp_pkg::COEF_A_RST;
      coef_b_q    <= adp_pkg::COEF_B_RST;
      coef_c_q    <= adp_pkg::COEF_C_RST;
      coef_d_q    <= adp_pkg::COEF_D_RST;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      issue_cnt_q <= '0;
      res_cnt_q   <= '0;
      incr_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          adp_pkg::CFG_COEF_A: coef_a_q <= cfg_data_i;
          adp_pkg::CFG_COEF_B: coef_b_q <= cfg_data_i;
          adp_pkg::CFG_COEF_C: coef_c_q <= cfg_data_i;
          adp_pkg::CFG_COEF_D: coef_d_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        incr_q <= (in_action == adp_pkg::ACT_ITERATE);
        if (in_action == adp_pkg::ACT_RESTART) begin
          cur_x_q <= in_seed_x;
          cur_y_q <= in_seed_y;
        end
      end
      if (state_q == adp_pkg::ST_ISSUE) begin
        issue_cnt_q <= issue_cnt_q + 2'd1;
      end
      if (state_q == adp_pkg::ST_COLLECT && phs_rsp.valid) begin
        res_cnt_q <= res_cnt_q + 2'd1;
        if (res_cnt_q == 2'd3) begin
          cur_x_q <= nx_q;
          cur_y_q <= ny_q - phs_val;
        end
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_row_q  <= '0;
      res_col_q  <= '0;
      count_q    <= '0;
      addr_row_q <= in_row_ext[adp_pkg::ROW_W-1:0];
      addr_col_q <= in_col_ext[adp_pkg::COL_W-1:0];
      if (in_action == adp_pkg::ACT_READ) begin
        res_row_q <= in_row;
        res_col_q <= in_col;
      end
    end
    if (state_q == adp_pkg::ST_COLLECT && phs_rsp.valid) begin
      case (res_cnt_q)
        2'd0:    nx_q <= phs_val;
        2'd1:    nx_q <= nx_q - phs_val;
        2'd2:    ny_q <= phs_val;
        default: ny_q <= ny_q - phs_val;
      endcase
    end
    if (state_q == adp_pkg::ST_PIXEL) begin
      addr_row_q <= row_idx[adp_pkg::ROW_W-1:0];
      addr_col_q <= col_idx[adp_pkg::COL_W-1:0];
      res_row_q  <= row_out_ext[adp_pkg::FIELD_W-1:0];
      res_col_q  <= col_out_ext[adp_pkg::FIELD_W-1:0];
    end
    if (state_q == adp_pkg::ST_WAIT_MEM && dens_rsp.valid) begin
      count_q <= dens_rsp.count;
    end
    if (emit) begin
      m_data_q <= {6'b0, count_q, res_col_q, res_row_q, cur_y_q, cur_x_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  a_phs_in_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phs_rsp.valid |-> state_q == adp_pkg::ST_COLLECT)
    else $error("sine result outside collect phase");

  a_mem_rsp_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dens_rsp.valid |-> state_q == adp_pkg::ST_WAIT_MEM)
    else $error("image response outside wait phase");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> count_q <= adp_pkg::HIT_MAX)
    else $error("hit count above saturation");

endmodule
